[rtl/core/cbd_pkg.sv]
// Shared types and constants for the chunked body decoder.
// Beat payload structs, character codes, end reason codes, output queue sizing.
// No dependencies.
package cbd_pkg;

    localparam int FIELD_W     = 24;
    localparam int TRAILER_LEN = 2;

    localparam logic [FIELD_W-1:0] MAX_BYTES_RESET = 24'd1048576;

    // output queue: room for the two items one input beat can produce, plus slack
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [2:0] REASON_ZERO       = 3'd0;
    localparam logic [2:0] REASON_ENDED      = 3'd1;
    localparam logic [2:0] REASON_MALFORMED  = 3'd2;
    localparam logic [2:0] REASON_INCOMPLETE = 3'd3;
    localparam logic [2:0] REASON_LIMIT      = 3'd4;
    localparam logic [2:0] STOP_NONE         = 3'd7;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       last_byte;
    } cbd_in_t;

    typedef struct packed {
        logic               item_kind;
        logic [7:0]         data_byte;
        logic [FIELD_W-1:0] decoded_count;
        logic               truncated;
        logic [FIELD_W-1:0] discard_count;
        logic [2:0]         end_reason;
        logic               is_last;
    } cbd_out_t;

    // items produced by one accepted input beat
    typedef struct packed {
        logic     data_en;
        logic     rpt_en;
        cbd_out_t data_item;
        cbd_out_t rpt_item;
    } cbd_push_t;

endpackage

[rtl/core/cbd_parser.sv]
// Chunk-size line parser, data pass-through and final report generation.
// Holds the decode state and the byte limit register; one input beat per cycle when accept is high.
// Depends on cbd_pkg.
module cbd_parser
    import cbd_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [FIELD_W-1:0]   cfg_wr_data,
    input  logic                 accept,
    input  cbd_in_t              in_data,
    output cbd_push_t            push
);

    localparam int CW   = COUNT_BITS;
    localparam int CMPW = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

    typedef enum logic [2:0] {
        PH_LWS,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_TAIL,
        PH_DATA,
        PH_SKIP
    } phase_t;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end
        return r;
    endfunction

    phase_t             phase_reg, phase_next;
    logic               held_cr_reg, held_cr_next;
    logic               digit_reg, digit_next;
    logic [CW-1:0]      size_reg, size_next;
    logic [CW-1:0]      left_reg, left_next;
    logic [CW-1:0]      chunk_reg, chunk_next;
    logic [CW-1:0]      commit_reg, commit_next;
    logic [2:0]         stop_reg, stop_next;
    logic [FIELD_W-1:0] max_reg;

    logic [7:0]    c;
    logic [4:0]    hx;
    logic          is_space;
    logic [CW-1:0] add_val;
    logic [CW-1:0] ce1;
    logic [CW-1:0] bl1;
    logic [CW:0]   sum_wide;
    logic [CW-1:0] commit_sum;
    logic          lead_digit;

    assign c        = in_data.body_byte;
    assign hx       = hex_digit(c);
    assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    // shifting in a digit overflows exactly when the top nibble is nonzero
    assign add_val  = (|size_reg[CW-1 -: 4]) ? '1 : {size_reg[CW-5:0], hx[3:0]};
    assign ce1      = chunk_reg + CW'(1);
    assign bl1      = left_reg - CW'(1);
    assign sum_wide = {1'b0, commit_reg} + {1'b0, ce1};
    assign commit_sum = sum_wide[CW] ? '1 : sum_wide[CW-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        held_cr_next = held_cr_reg;
        digit_next   = digit_reg;
        size_next    = size_reg;
        left_next    = left_reg;
        chunk_next   = chunk_reg;
        commit_next  = commit_reg;
        stop_next    = stop_reg;
        lead_digit   = 1'b0;
        push         = '0;

        push.data_item.item_kind = KIND_DATA;
        push.data_item.data_byte = c;

        if (accept) begin
            if (stop_reg == STOP_NONE) begin
                unique case (phase_reg)
                    PH_DATA:
                    begin
                        push.data_en = 1'b1;
                        if (bl1 == '0) begin
                            commit_next = commit_sum;
                            chunk_next  = '0;
                            if (CMPW'(commit_sum) >= CMPW'(max_reg)) begin
                                stop_next = REASON_LIMIT;
                                left_next = bl1;
                            end else begin
                                phase_next = PH_SKIP;
                                left_next  = CW'(TRAILER_LEN);
                            end
                        end else begin
                            chunk_next = ce1;
                            left_next  = bl1;
                        end
                    end
                    PH_SKIP:
                    begin
                        left_next = bl1;
                        if (bl1 == '0) begin
                            phase_next   = PH_LWS;
                            held_cr_next = 1'b0;
                            digit_next   = 1'b0;
                            size_next    = '0;
                        end
                    end
                    default:
                    begin
                        if (c == CH_LF && held_cr_reg) begin
                            // end of size line
                            if (!digit_reg) begin
                                stop_next = REASON_MALFORMED;
                            end else if (size_reg == '0) begin
                                stop_next = REASON_ZERO;
                            end else begin
                                phase_next = PH_DATA;
                                left_next  = size_reg;
                                chunk_next = '0;
                            end
                            held_cr_next = 1'b0;
                        end else begin
                            case (phase_reg)
                                PH_LWS:
                                begin
                                    if (c == CH_PLUS) begin
                                        phase_next = PH_SIGNED;
                                    end else if (!is_space) begin
                                        lead_digit = 1'b1;
                                    end
                                end
                                PH_SIGNED:
                                begin
                                    lead_digit = 1'b1;
                                end
                                PH_ZERO:
                                begin
                                    if (c == CH_LX || c == CH_UX) begin
                                        phase_next = PH_PREFIX;
                                    end else if (hx[4]) begin
                                        size_next  = add_val;
                                        digit_next = 1'b1;
                                        phase_next = PH_DIGITS;
                                    end else begin
                                        phase_next = PH_TAIL;
                                    end
                                end
                                PH_PREFIX, PH_DIGITS:
                                begin
                                    if (hx[4]) begin
                                        size_next  = add_val;
                                        digit_next = 1'b1;
                                        phase_next = PH_DIGITS;
                                    end else begin
                                        phase_next = PH_TAIL;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                            if (lead_digit) begin
                                if (hx[4]) begin
                                    size_next  = add_val;
                                    digit_next = 1'b1;
                                    phase_next = (c == CH_ZERO) ? PH_ZERO : PH_DIGITS;
                                end else begin
                                    // includes a minus sign: line ends up malformed
                                    phase_next = PH_TAIL;
                                end
                            end
                            held_cr_next = (c == CH_CR);
                        end
                    end
                endcase
            end

            if (in_data.last_byte) begin
                push.rpt_en                 = 1'b1;
                push.rpt_item.item_kind     = KIND_REPORT;
                push.rpt_item.is_last       = 1'b1;
                push.rpt_item.decoded_count = FIELD_W'(commit_next);
                push.rpt_item.truncated     = (CMPW'(commit_next) >= CMPW'(max_reg));
                if (stop_next != STOP_NONE) begin
                    push.rpt_item.end_reason = stop_next;
                end else if (phase_next == PH_DATA) begin
                    push.rpt_item.end_reason    = REASON_INCOMPLETE;
                    push.rpt_item.discard_count = FIELD_W'(chunk_next);
                end else begin
                    push.rpt_item.end_reason = REASON_ENDED;
                end

                // fresh body follows
                phase_next   = PH_LWS;
                held_cr_next = 1'b0;
                digit_next   = 1'b0;
                size_next    = '0;
                left_next    = '0;
                chunk_next   = '0;
                commit_next  = '0;
                stop_next    = STOP_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_LWS;
            held_cr_reg <= 1'b0;
            digit_reg   <= 1'b0;
            size_reg    <= '0;
            left_reg    <= '0;
            chunk_reg   <= '0;
            commit_reg  <= '0;
            stop_reg    <= STOP_NONE;
            max_reg     <= MAX_BYTES_RESET;
        end else begin
            phase_reg   <= phase_next;
            held_cr_reg <= held_cr_next;
            digit_reg   <= digit_next;
            size_reg    <= size_next;
            left_reg    <= left_next;
            chunk_reg   <= chunk_next;
            commit_reg  <= commit_next;
            stop_reg    <= stop_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last_byte |=> commit_reg == '0 && stop_reg == STOP_NONE
            && phase_reg == PH_LWS)
        else $error("decode state not cleared after last beat");

    a_no_data_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        push.data_en |-> stop_reg == STOP_NONE && phase_reg == PH_DATA)
        else $error("data beat emitted outside an active chunk");

    a_data_has_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA && stop_reg == STOP_NONE |-> left_reg != '0)
        else $error("active chunk with zero bytes left");

endmodule

[rtl/core/cbd_out_fifo.sv]
// Small output queue taking up to two items per cycle and giving one unless out_stall is high.
// Parts the parser from the output handshake. Depends on cbd_pkg.
module cbd_out_fifo
    import cbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cbd_push_t push,
    output logic      full,
    output logic      out_valid,
    input  logic      out_stall,
    output cbd_out_t  out_data
);

    cbd_out_t         mem [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CW-1:0] count_reg, count_next;
    logic [1:0]       n_push;
    logic             pop;
    cbd_out_t         first_item;

    assign n_push     = 2'(push.data_en) + 2'(push.rpt_en);
    assign first_item = push.data_en ? push.data_item : push.rpt_item;
    assign out_valid  = (count_reg != '0);
    assign out_data   = mem[rd_ptr_reg];
    assign pop        = out_valid && !out_stall;
    // signal full while fewer than two entries are free
    assign full       = (count_reg > OQ_CW'(OQ_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + OQ_AW'(n_push);
    assign rd_ptr_next = rd_ptr_reg + OQ_AW'(pop);
    assign count_next  = count_reg + OQ_CW'(n_push) - OQ_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0) begin
            mem[wr_ptr_reg] <= first_item;
        end
        if (n_push == 2'd2) begin
            mem[wr_ptr_reg + OQ_AW'(1)] <= push.rpt_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OQ_CW'(OQ_DEPTH))
        else $error("output queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        n_push != 2'd0 |-> count_reg <= OQ_CW'(OQ_DEPTH - 2))
        else $error("push into queue without room for two beats");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && n_push == 2'd0 |=> count_reg == $past(count_reg) - OQ_CW'(1))
        else $error("queue count wrong after pop");

endmodule

[rtl/core/http_chunked_body_decoder_unit.sv]
// HTTP/1.1 chunked body decoder, one raw body byte per input beat.
// Input beat: body_byte, last_byte. Output beat: a decoded data byte or the final
// report (decoded count, truncated, discard count, end reason).
// A chunk's data bytes come out as data beats; size lines and CRLF trailers
// produce nothing. The beat flagged last_byte adds one report beat, after the
// data beat it may also carry, and returns the decode state to its reset values.
// Throughput: one input beat per cycle while in_stall is low; a last beat that
// also carries a data byte makes two output beats, drained one per cycle while
// out_stall is low, through a 4-entry output queue. in_stall rises while that
// queue holds more than two beats, so a stalled receiver backs up into the
// input once three beats are queued.
// cfg_wr_en/cfg_wr_data write the byte limit (reset 1048576); write it only
// while idle. Reset clears the decode state and the queue and restores the limit.
// COUNT_BITS sets the width of the internal size and byte counters.
// Depends on cbd_pkg, cbd_parser, cbd_out_fifo.
module http_chunked_body_decoder_unit
    import cbd_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  cbd_in_t            in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output cbd_out_t           out_data
);

    cbd_push_t push;
    logic      accept;

    assign accept = in_valid && !in_stall;

    cbd_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_data     (in_data),
        .push        (push)
    );

    cbd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[tb/sv/chunked_decode_checker.sv]
`timescale 1ns / 1ps
// Checker for http_chunked_body_decoder_unit: watches the config port and both
// channels, predicts the decoded beats and compares them. Depends on cbd_pkg.
module chunked_decode_checker
    import cbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  cbd_in_t            in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  cbd_out_t           out_data,
    output int                 fail_count,
    output int                 pending_count
);

    typedef enum logic [2:0] {
        LINE_LWS, LINE_SIGN, LINE_ZERO, LINE_PREFIX,
        LINE_DIGITS, LINE_TAIL, LINE_DATA, LINE_TRAILER
    } line_phase_t;

    localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

    logic [FIELD_W-1:0] byte_limit;
    line_phase_t        phase;
    logic               held_cr;
    logic               digit_seen;
    logic [FIELD_W-1:0] size_acc;
    logic [FIELD_W-1:0] left_in_chunk;
    logic [FIELD_W-1:0] chunk_sent;
    logic [FIELD_W-1:0] committed;
    logic [2:0]         stop_code;

    cbd_out_t awaited_beats[$];
    int       mismatch_total;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_LA && c <= CH_LF_HEX) return c - CH_LA + 10;
        if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
        return -1;
    endfunction

    function automatic bit is_white(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic restart_line();
        phase      = LINE_LWS;
        held_cr    = 1'b0;
        digit_seen = 1'b0;
        size_acc   = '0;
    endtask

    task automatic clear_body();
        restart_line();
        left_in_chunk = '0;
        chunk_sent    = '0;
        committed     = '0;
        stop_code     = STOP_NONE;
    endtask

    // saturating accumulate of one hex digit
    task automatic take_digit(input int d);
        logic [27:0] grown;
        grown = {4'd0, size_acc} * 28'd16 + 28'(d);
        size_acc   = (grown > 28'(COUNT_MAX)) ? COUNT_MAX : grown[FIELD_W-1:0];
        digit_seen = 1'b1;
    endtask

    // first character of the number, after whitespace or a sign
    task automatic number_start(input logic [7:0] c);
        int h;
        h = hex_digit(c);
        if (c == CH_ZERO)
        begin
            take_digit(0);
            phase = LINE_ZERO;
        end
        else if (h >= 0)
        begin
            take_digit(h);
            phase = LINE_DIGITS;
        end
        else
            phase = LINE_TAIL;
    endtask

    task automatic size_line_char(input logic [7:0] c);
        int h;
        h = hex_digit(c);
        if (c == CH_LF && held_cr)
        begin
            if (!digit_seen)
                stop_code = REASON_MALFORMED;
            else if (size_acc == 0)
                stop_code = REASON_ZERO;
            else
            begin
                phase         = LINE_DATA;
                left_in_chunk = size_acc;
                chunk_sent    = '0;
            end
            held_cr = 1'b0;
            return;
        end
        case (phase)
            LINE_LWS:
                if (is_white(c))
                    ;
                else if (c == CH_PLUS)
                    phase = LINE_SIGN;
                else
                    number_start(c);
            LINE_SIGN:
                number_start(c);
            LINE_ZERO:
                if (c == CH_LX || c == CH_UX)
                    phase = LINE_PREFIX;
                else if (h >= 0)
                begin
                    take_digit(h);
                    phase = LINE_DIGITS;
                end
                else
                    phase = LINE_TAIL;
            LINE_PREFIX, LINE_DIGITS:
                if (h >= 0)
                begin
                    take_digit(h);
                    phase = LINE_DIGITS;
                end
                else
                    phase = LINE_TAIL;
            default:
                ;
        endcase
        held_cr = (c == CH_CR);
    endtask

    task automatic decode_body_byte(input logic [7:0] c, input logic last);
        cbd_out_t           beat;
        logic [FIELD_W:0]   sum;
        logic [2:0]         reason;
        logic [FIELD_W-1:0] discard;
        if (stop_code == STOP_NONE)
        begin
            if (phase == LINE_DATA)
            begin
                beat = '0;
                beat.item_kind = KIND_DATA;
                beat.data_byte = c;
                awaited_beats.push_back(beat);
                chunk_sent    = chunk_sent + 1'b1;
                left_in_chunk = left_in_chunk - 1'b1;
                if (left_in_chunk == 0)
                begin
                    sum        = {1'b0, committed} + {1'b0, chunk_sent};
                    committed  = sum[FIELD_W] ? COUNT_MAX : sum[FIELD_W-1:0];
                    chunk_sent = '0;
                    if (committed >= byte_limit)
                        stop_code = REASON_LIMIT;
                    else
                    begin
                        phase         = LINE_TRAILER;
                        left_in_chunk = FIELD_W'(TRAILER_LEN);
                    end
                end
            end
            else if (phase == LINE_TRAILER)
            begin
                left_in_chunk = left_in_chunk - 1'b1;
                if (left_in_chunk == 0)
                    restart_line();
            end
            else
                size_line_char(c);
        end
        if (last)
        begin
            discard = '0;
            if (stop_code != STOP_NONE)
                reason = stop_code;
            else if (phase == LINE_DATA)
            begin
                reason  = REASON_INCOMPLETE;
                discard = chunk_sent;
            end
            else
                reason = REASON_ENDED;
            beat = '0;
            beat.item_kind     = KIND_REPORT;
            beat.decoded_count = committed;
            beat.truncated     = (committed >= byte_limit);
            beat.discard_count = discard;
            beat.end_reason    = reason;
            beat.is_last       = 1'b1;
            awaited_beats.push_back(beat);
            clear_body();
        end
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, field,
                         want, got);
        end
    endtask

    task automatic check_beat(input cbd_out_t got);
        cbd_out_t want;
        if (awaited_beats.size() == 0)
        begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display("%0t: unexpected output beat %h", $realtime, got);
            return;
        end
        want = awaited_beats.pop_front();
        compare_field("item_kind", want.item_kind, got.item_kind);
        compare_field("data_byte", want.data_byte, got.data_byte);
        compare_field("decoded_count", want.decoded_count, got.decoded_count);
        compare_field("truncated", want.truncated, got.truncated);
        compare_field("discard_count", want.discard_count, got.discard_count);
        compare_field("end_reason", want.end_reason, got.end_reason);
        compare_field("is_last", want.is_last, got.is_last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_limit = MAX_BYTES_RESET;
            clear_body();
            awaited_beats.delete();
            mismatch_total = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            // an output beat always stems from an earlier input beat
            if (out_valid && !out_stall)
                check_beat(out_data);
            if (cfg_wr_en)
                byte_limit = cfg_wr_data;
            if (in_valid && !in_stall)
                decode_body_byte(in_data.body_byte, in_data.last_byte);
            fail_count    <= mismatch_total;
            pending_count <= awaited_beats.size();
        end
    end

endmodule

[tb/sv/tb_http_chunked_body_decoder_unit.sv]
`timescale 1ns / 1ps
// Top of the chunked body decoder testbench: clock, reset, body stimulus, stalls.
// Depends on cbd_pkg, http_chunked_body_decoder_unit, chunked_decode_checker.
module tb_http_chunked_body_decoder_unit;
    import cbd_pkg::*;

    localparam int         RUN_LIMIT   = 200000;
    localparam int         PHASE_BYTES = 175;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [FIELD_W-1:0] cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    cbd_in_t            in_data     = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    cbd_out_t           out_data;
    int                 fail_count;
    int                 pending_count;

    bit         calm = 1'b0;
    int         cycles = 0;
    int         sent_bytes = 0;
    logic [7:0] body_bytes[$];

    http_chunked_body_decoder_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    chunked_decode_checker decode_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 35);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            body_bytes.push_back(s[k]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 10)
            return CH_ZERO + 8'(nib);
        return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] white_char();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    // size line in a random but well-formed spelling, ending in CRLF
    task automatic put_size_line(input logic [39:0] size);
        int nd;
        int k;
        repeat ($urandom_range(2))
            body_bytes.push_back(white_char());
        if ($urandom_range(4) == 0)
            body_bytes.push_back(CH_PLUS);
        if (size == 0 && $urandom_range(3) == 0)
        begin
            // bare prefix: the zero already read stands
            body_bytes.push_back(CH_ZERO);
            body_bytes.push_back($urandom_range(1) ? CH_LX : CH_UX);
        end
        else
        begin
            if ($urandom_range(4) == 0)
            begin
                body_bytes.push_back(CH_ZERO);
                body_bytes.push_back($urandom_range(1) ? CH_LX : CH_UX);
            end
            repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
                body_bytes.push_back(CH_ZERO);
            nd = 1;
            while (nd < 10 && (size >> (4 * nd)) != 0)
                nd++;
            for (k = nd - 1; k >= 0; k--)
                body_bytes.push_back(hex_char(size[4*k +: 4]));
        end
        if ($urandom_range(3) == 0)
        begin
            body_bytes.push_back(CH_SEMI);
            repeat ($urandom_range(1, 3))
                body_bytes.push_back(8'($urandom_range(8'h7E, 8'h21)));
        end
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
    endtask

    task automatic put_data(input int n);
        repeat (n)
            body_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_trailer();
        if ($urandom_range(9) == 0)
            put_data(2);
        else
        begin
            body_bytes.push_back(CH_CR);
            body_bytes.push_back(CH_LF);
        end
    endtask

    task automatic put_chunk(input int size);
        put_size_line(40'(size));
        put_data(size);
        put_trailer();
    endtask

    task automatic build_body();
        int pick;
        int s;
        body_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            put_data($urandom_range(1, 12));
            return;
        end
        if (pick < 25)
        begin
            repeat ($urandom_range(2))
                put_chunk($urandom_range(1, 10));
            case ($urandom_range(4))
                0: body_bytes.push_back(CH_MINUS);
                1: body_bytes.push_back(CH_PLUS);
                2: push_text("g7");
                3: body_bytes.push_back(white_char());
                default: ;
            endcase
            if ($urandom_range(1))
                body_bytes.push_back(hex_char(4'($urandom_range(15))));
            push_text("\r\n");
            put_data($urandom_range(4));
            return;
        end
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(24) == 0)
            begin
                // maximal or oversized (saturating) size; body ends inside the chunk
                put_size_line($urandom_range(1) ? 40'hFFFFFF
                              : {8'($urandom_range(255, 1)), 32'($urandom)});
                put_data($urandom_range(1, 6));
                return;
            end
            put_chunk($urandom_range(1, 12));
        end
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            put_size_line(40'd0);
            if ($urandom_range(1))
                put_trailer();
            put_data($urandom_range(2));
        end
        else if (pick < 70)
            ;
        else if (pick < 85)
        begin
            s = $urandom_range(2, 12);
            put_size_line(40'(s));
            put_data($urandom_range(1, s - 1));
        end
        else if (pick < 93)
        begin
            repeat ($urandom_range(1, 3))
                body_bytes.push_back(hex_char(4'($urandom_range(15))));
        end
        else
        begin
            s = $urandom_range(1, 6);
            put_size_line(40'(s));
            put_data(s);
            body_bytes.push_back(CH_CR);
        end
    endtask

    // valid stays up across back-to-back beats and stalls; dropped only for random idle cycles
    task automatic send_beat(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{body_byte: b, last_byte: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_body();
        int k;
        for (k = 0; k < body_bytes.size(); k++)
            send_beat(body_bytes[k], k == body_bytes.size() - 1);
    endtask

    task automatic drain_and_set_limit(input logic [FIELD_W-1:0] limit);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [FIELD_W-1:0] limits[5];
        int                 p;
        int                 phase_end;
        limits[0] = 24'd1;
        limits[1] = 24'hFFFFFF;
        limits[2] = 24'd0;
        limits[3] = 24'($urandom_range(60, 2));
        limits[4] = 24'd20;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: minus sign with bytes after the stop, bare 0x prefix,
        // extreme data bytes with a short trailer, saturated oversized size
        body_bytes.delete();
        push_text("-1\r\nX");
        send_body();
        body_bytes.delete();
        push_text("0x\r\n");
        send_body();
        body_bytes.delete();
        push_text(" 2\r\n");
        body_bytes.push_back(8'h00);
        body_bytes.push_back(8'hFF);
        body_bytes.push_back(CH_CR);
        send_body();
        body_bytes.delete();
        push_text("+0XfffFFFFFF\r\nz");
        send_body();

        for (p = 0; p < 6; p++)
        begin
            if (p > 0)
                drain_and_set_limit(limits[p-1]);
            calm = (p == 2);
            phase_end = sent_bytes + PHASE_BYTES;
            while (sent_bytes < phase_end)
            begin
                build_body();
                send_body();
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
